@@ sv/lzss_window_decompressor_core_defines.svh @@
// Assertion macros shared by the checker of the LZSS window decompressor.
// Depends on nothing; included by the checker file only.
`ifndef LZSS_WINDOW_DECOMPRESSOR_CORE_DEFINES_SVH
`define LZSS_WINDOW_DECOMPRESSOR_CORE_DEFINES_SVH

// Checks a property on every rising clock edge outside of reset.
`define LZWD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lzwd: assertion failed");

// Checks a property on every rising clock edge, reset cycles included.
`define LZWD_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("lzwd: reset assertion failed");

`endif

@@ sv/lzwd_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants and controller/datapath interface types of the LZSS
// window decompressor. Depends on nothing.
package lzwd_pkg;

    localparam int WINDOW_SIZE = 4096;
    localparam int WIN_AW      = $clog2(WINDOW_SIZE);
    localparam int LEN_W       = 9;

    localparam logic [3:0]       LEN_EXT_CODE = 4'hf;
    localparam logic [LEN_W-1:0] LEN_BASE     = 9'd3;
    localparam logic [LEN_W-1:0] LEN_EXT_BASE = 9'd18;
    localparam logic [3:0]       FLAG_BITS    = 4'd8;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr;         // zero one window entry of the clearing pass
        logic load_in;     // capture the incoming word
        logic lit_emit;    // store the literal in the window and emit it
        logic set_pos_lo;  // low byte of the match position
        logic set_pos_hi;  // high nibble of the position and the length code
        logic set_len_ext; // length extension byte
        logic copy_rd;     // read the window at the match source
        logic copy_wr;     // write the read byte back and emit it
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_start;
        logic       len_one;   // the byte being copied is the last of the match
        logic       clr_last;  // the clearing pass is at its final entry
        logic       out_free;  // the output register can take a result now
    } t_sts;

endpackage

@@ sv/lzwd_ctrl.sv @@
`timescale 1ns / 1ps
// Controller of the LZSS window decompressor: token parse state and sequencing.
// Depends on lzwd_pkg for the command and status types.
module lzwd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  lzwd_pkg::t_sts i_sts,
    output lzwd_pkg::t_cmd o_cmd
);
    import lzwd_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_READ,
        ST_WRITE
    } t_state;

    typedef enum logic [1:0] {
        PH_START,
        PH_POS_HI,
        PH_LEN_EXT
    } t_phase;

    t_state     r_state;
    t_phase     r_phase;
    logic [7:0] r_flag_shift;
    logic [3:0] r_flags_left;

    t_phase     w_phase;
    logic [3:0] w_flags_left;

    // A block start drops any partial token and expects a flag byte.
    assign w_phase      = i_sts.in_start ? PH_START : r_phase;
    assign w_flags_left = i_sts.in_start ? 4'd0 : r_flags_left;

    assign o_in_stall = (r_state != ST_IDLE);

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ST_CLEAR: o_cmd.clr = 1'b1;
            ST_IDLE:  o_cmd.load_in = i_in_valid;
            ST_DECODE: begin
                unique case (w_phase)
                    PH_POS_HI:  o_cmd.set_pos_hi = 1'b1;
                    PH_LEN_EXT: o_cmd.set_len_ext = 1'b1;
                    default: begin
                        if (w_flags_left != 4'd0) begin
                            if (!r_flag_shift[0]) begin
                                o_cmd.lit_emit = i_sts.out_free;
                            end else begin
                                o_cmd.set_pos_lo = 1'b1;
                            end
                        end
                    end
                endcase
            end
            ST_READ:  o_cmd.copy_rd = 1'b1;
            ST_WRITE: o_cmd.copy_wr = i_sts.out_free;
            default:  o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_phase      <= PH_START;
            r_flag_shift <= '0;
            r_flags_left <= '0;
        end else begin
            unique case (r_state)
                ST_CLEAR: begin
                    if (i_sts.clr_last) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= ST_DECODE;
                    end
                end
                ST_DECODE: begin
                    unique case (w_phase)
                        PH_POS_HI: begin
                            if (i_sts.in_byte[7:4] == LEN_EXT_CODE) begin
                                r_phase <= PH_LEN_EXT;
                                r_state <= ST_IDLE;
                            end else begin
                                r_flag_shift <= {1'b0, r_flag_shift[7:1]};
                                r_flags_left <= r_flags_left - 4'd1;
                                r_phase      <= PH_START;
                                r_state      <= ST_READ;
                            end
                        end
                        PH_LEN_EXT: begin
                            r_flag_shift <= {1'b0, r_flag_shift[7:1]};
                            r_flags_left <= r_flags_left - 4'd1;
                            r_phase      <= PH_START;
                            r_state      <= ST_READ;
                        end
                        default: begin
                            r_phase <= PH_START;
                            if (w_flags_left == 4'd0) begin
                                r_flag_shift <= i_sts.in_byte;
                                r_flags_left <= FLAG_BITS;
                                r_state      <= ST_IDLE;
                            end else if (!r_flag_shift[0]) begin
                                if (i_sts.out_free) begin
                                    r_flag_shift <= {1'b0, r_flag_shift[7:1]};
                                    r_flags_left <= r_flags_left - 4'd1;
                                    r_state      <= ST_IDLE;
                                end
                            end else begin
                                r_phase <= PH_POS_HI;
                                r_state <= ST_IDLE;
                            end
                        end
                    endcase
                end
                ST_READ: r_state <= ST_WRITE;
                ST_WRITE: begin
                    if (i_sts.out_free) begin
                        r_state <= i_sts.len_one ? ST_IDLE : ST_READ;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

@@ sv/lzwd_dpath.sv @@
`timescale 1ns / 1ps
// Datapath of the LZSS window decompressor: history window, pointers, lane
// packing and the output register. Depends on lzwd_pkg.
module lzwd_dpath #(
    parameter int OUT_LANES = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [7:0]     i_in_byte,
    input  logic           i_block_start,
    input  lzwd_pkg::t_cmd i_cmd,
    output lzwd_pkg::t_sts o_sts,
    input  logic           i_out_stall,
    output logic           o_out_valid,
    output logic [63:0]    o_out_bytes,
    output logic [3:0]     o_out_count,
    output logic           o_out_last
);
    import lzwd_pkg::*;

    localparam int LaneW = (OUT_LANES > 1) ? $clog2(OUT_LANES) : 1;

    logic [7:0]        r_window [WINDOW_SIZE];
    logic [7:0]        r_in;
    logic              r_start;
    logic [WIN_AW-1:0] r_wp;
    logic [WIN_AW-1:0] r_src;
    logic [WIN_AW-1:0] r_clr_addr;
    logic [LEN_W-1:0]  r_len;
    logic [7:0]        r_rd;
    logic [63:0]       r_word;
    logic [3:0]        r_fill;
    logic              r_out_valid;
    logic [63:0]       r_out_bytes;
    logic [3:0]        r_out_count;
    logic              r_out_last;

    logic              w_we;
    logic [WIN_AW-1:0] w_waddr;
    logic [7:0]        w_wdata;
    logic              w_emit;
    logic              w_last;
    logic              w_push;
    logic              w_out_free;
    logic [7:0]        w_byte;
    logic [3:0]        n_fill;
    logic [63:0]       n_word;
    logic [LaneW-1:0]  w_lane;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_emit     = i_cmd.lit_emit || i_cmd.copy_wr;
    assign w_byte     = i_cmd.lit_emit ? r_in : r_rd;
    assign w_last     = i_cmd.lit_emit || (r_len == LEN_W'(1));
    assign n_fill     = r_fill + 4'd1;
    assign w_push     = w_emit && ((n_fill == 4'(OUT_LANES)) || w_last);
    assign w_lane     = r_fill[LaneW-1:0];

    always_comb begin
        n_word = r_word;
        n_word[w_lane*8 +: 8] = w_byte;
    end

    assign w_we    = i_cmd.clr || w_emit;
    assign w_waddr = i_cmd.clr ? r_clr_addr : r_wp;
    assign w_wdata = i_cmd.clr ? 8'd0 : w_byte;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_window[w_waddr] <= w_wdata;
        end
        if (i_cmd.copy_rd) begin
            r_rd <= r_window[r_src];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in    <= i_in_byte;
            r_start <= i_block_start;
        end
        if (i_cmd.set_pos_lo) begin
            r_src <= WIN_AW'(r_in);
        end else if (i_cmd.set_pos_hi) begin
            r_src <= {r_in[3:0], r_src[7:0]};
        end else if (i_cmd.copy_rd) begin
            r_src <= r_src + WIN_AW'(1);
        end
        if (i_cmd.set_pos_hi) begin
            r_len <= LEN_W'(r_in[7:4]) + LEN_BASE;
        end else if (i_cmd.set_len_ext) begin
            r_len <= LEN_EXT_BASE + LEN_W'(r_in);
        end else if (i_cmd.copy_wr) begin
            r_len <= r_len - LEN_W'(1);
        end
        if (w_push) begin
            r_out_bytes <= n_word;
            r_out_count <= n_fill;
            r_out_last  <= w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_clr_addr  <= '0;
            r_word      <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr) begin
                r_clr_addr <= r_clr_addr + WIN_AW'(1);
            end
            if (w_emit) begin
                r_wp <= r_wp + WIN_AW'(1);
                if (w_push) begin
                    r_word <= '0;
                    r_fill <= '0;
                end else begin
                    r_word <= n_word;
                    r_fill <= n_fill;
                end
            end
            if (w_push) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.in_byte  = r_in;
    assign o_sts.in_start = r_start;
    assign o_sts.len_one  = (r_len == LEN_W'(1));
    assign o_sts.clr_last = &r_clr_addr;
    assign o_sts.out_free = w_out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_bytes = r_out_bytes;
    assign o_out_count = r_out_count;
    assign o_out_last  = r_out_last;

endmodule

@@ sv/lzss_window_decompressor_core.sv @@
`timescale 1ns / 1ps
// Handshake: a word is taken in the idle state and decoded in the decode state;
// a literal's result is written to the output register once that is free.
// Flow: the input stalls while a word is decoded, so no new word is taken
// before the last is done; a match word's bytes go through the window in turn.
// Reset: synchronous, active low; then a clearing pass zeroes the window,
// with the input stalled, before the first word is taken.
//
// LZSS decompressor with a 4096-byte history window. Each accepted word is
// a flag byte, a match descriptor byte, a length extension byte or a literal.
// The controller module keeps the token parse state (remaining flag bits,
// flag count and token phase) and steps the datapath through the work of a
// word. The datapath holds the window memory, the write pointer, the match
// source pointer and remaining length, and packs decoded bytes into lanes of
// up to OUT_LANES bytes before they go to the output register.
//
// For each match byte, the window is first read at the source pointer into a
// register; then, in the write state, the registered byte is written back at
// the write pointer and emitted. Because each write finishes before the next read,
// overlapping source and destination ranges repeat bytes as expected.
// The output register decouples the two channels; the datapath only emits a
// byte when the register is empty or being drained in the same cycle.
module lzss_window_decompressor_core #(
    parameter int OUT_LANES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_block_start,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_out_bytes,
    output logic [3:0]  o_out_count,
    output logic        o_out_last
);
    import lzwd_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // Token parsing and sequencing.
    lzwd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Window, pointers, lane packing and the output register.
    lzwd_dpath #(
        .OUT_LANES (OUT_LANES)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_byte     (i_in_byte),
        .i_block_start (i_block_start),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_out_bytes   (o_out_bytes),
        .o_out_count   (o_out_count),
        .o_out_last    (o_out_last)
    );

endmodule

@@ sv/lzwd_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the LZSS window decompressor and its bind.
// Depends on the assertion macros in the defines header.
`include "lzss_window_decompressor_core_defines.svh"

module lzwd_checker #(
    parameter int OUT_LANES = 8
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic [7:0]  i_in_byte,
    input logic        i_block_start,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [63:0] o_out_bytes,
    input logic [3:0]  o_out_count,
    input logic        o_out_last
);

    property p_out_hold;
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_out_bytes) && $stable(o_out_count)
             && $stable(o_out_last));
    endproperty

    property p_out_count;
        o_out_valid |-> (o_out_count != 4'd0 && o_out_count <= 4'(OUT_LANES));
    endproperty

    property p_one_word;
        (i_in_valid && !o_in_stall) |=> o_in_stall;
    endproperty

    property p_in_hold;
        (i_in_valid && o_in_stall) |=>
            (i_in_valid && $stable(i_in_byte) && $stable(i_block_start));
    endproperty

    property p_reset_quiet;
        !i_rst_n |=> (o_in_stall && !o_out_valid);
    endproperty

    // A stalled result stays in place with its payload.
    `LZWD_ASSERT(a_out_hold, i_clk, i_rst_n, p_out_hold)

    // A result carries between one and OUT_LANES bytes.
    `LZWD_ASSERT(a_out_count, i_clk, i_rst_n, p_out_count)

    // Each accepted word is decoded before the next one is taken.
    `LZWD_ASSERT(a_one_word, i_clk, i_rst_n, p_one_word)

    // A stalled input word stays offered with its payload.
    `LZWD_ASSERT(a_in_hold, i_clk, i_rst_n, p_in_hold)

    // After reset the window clearing pass holds off input and no result shows.
    `LZWD_ASSERT_ALWAYS(a_reset_quiet, i_clk, p_reset_quiet)

endmodule

bind lzss_window_decompressor_core lzwd_checker #(
    .OUT_LANES (OUT_LANES)
) u_lzwd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .i_in_byte     (i_in_byte),
    .i_block_start (i_block_start),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_out_bytes   (o_out_bytes),
    .o_out_count   (o_out_count),
    .o_out_last    (o_out_last)
);

@@ tb/lzss_window_decompressor_core_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the LZSS window decompressor: it watches both word channels,
// decodes every accepted input word on its own copy of the window and compares
// the output words in order. Depends on lzwd_pkg.
module lzss_window_decompressor_core_checker #(
    parameter int OUT_LANES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_block_start,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [63:0] i_out_bytes,
    input  logic [3:0]  i_out_count,
    input  logic        i_out_last,
    output int          o_error_count,
    output int          o_results_owed
);
    import lzwd_pkg::*;

    typedef enum logic [1:0] {
        PH_TOKEN,
        PH_POS_HI,
        PH_LEN_EXT
    } t_parse_phase;

    typedef struct packed {
        logic [63:0] bytes;
        logic [3:0]  count;
        logic        last;
    } t_out_word;

    logic [7:0]        window_mem [WINDOW_SIZE];
    logic [WIN_AW-1:0] wr_pos;
    logic [7:0]        flag_shift;
    logic [3:0]        flags_left;
    t_parse_phase      phase;
    logic [WIN_AW-1:0] match_pos;
    logic [3:0]        match_code;

    logic [63:0] lane_word;
    int          lane_fill;
    t_out_word   decoded_words[$];
    int          errors = 0;

    task automatic push_lanes();
        decoded_words.push_back('{bytes: lane_word, count: 4'(lane_fill), last: 1'b0});
        lane_word = '0;
        lane_fill = 0;
    endtask

    task automatic put_byte(input logic [7:0] value);
        window_mem[wr_pos] = value;
        wr_pos = wr_pos + 1'b1;
        lane_word[8*lane_fill +: 8] = value;
        lane_fill++;
        if (lane_fill == OUT_LANES) begin
            push_lanes();
        end
    endtask

    // Byte-serial copy: each byte is written back before the next is read,
    // so an overlapping source repeats what was just written.
    task automatic copy_match(input logic [WIN_AW-1:0] src, input logic [LEN_W-1:0] len);
        logic [7:0] value;
        for (int n = 0; n < len; n++) begin
            value = window_mem[src];
            src = src + 1'b1;
            put_byte(value);
        end
    endtask

    task automatic next_flag();
        flag_shift = flag_shift >> 1;
        flags_left = flags_left - 1'b1;
    endtask

    task automatic decode_word(input logic [7:0] value, input logic start);
        int first;
        first = decoded_words.size();
        lane_word = '0;
        lane_fill = 0;
        if (start) begin
            flags_left = '0;
            flag_shift = '0;
            phase = PH_TOKEN;
        end
        case (phase)
            PH_POS_HI: begin
                match_pos[11:8] = value[3:0];
                match_code = value[7:4];
                if (match_code == LEN_EXT_CODE) begin
                    phase = PH_LEN_EXT;
                end else begin
                    copy_match(match_pos, LEN_BASE + LEN_W'(match_code));
                    next_flag();
                    phase = PH_TOKEN;
                end
            end
            PH_LEN_EXT: begin
                copy_match(match_pos, LEN_EXT_BASE + LEN_W'(value));
                next_flag();
                phase = PH_TOKEN;
            end
            default: begin
                phase = PH_TOKEN;
                if (flags_left == 0) begin
                    flag_shift = value;
                    flags_left = FLAG_BITS;
                end else if (!flag_shift[0]) begin
                    put_byte(value);
                    next_flag();
                end else begin
                    match_pos = {4'h0, value};
                    phase = PH_POS_HI;
                end
            end
        endcase
        if (lane_fill != 0) begin
            push_lanes();
        end
        if (decoded_words.size() > first) begin
            decoded_words[decoded_words.size() - 1].last = 1'b1;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_out_word want;
        if (!i_rst_n) begin
            for (int a = 0; a < WINDOW_SIZE; a++) begin
                window_mem[WIN_AW'(a)] = 8'h00;
            end
            wr_pos = '0;
            flag_shift = '0;
            flags_left = '0;
            phase = PH_TOKEN;
            match_pos = '0;
            match_code = '0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (decoded_words.size() == 0) begin
                    $error("unexpected output word: out_bytes %h out_count %0d out_last %0b",
                           i_out_bytes, i_out_count, i_out_last);
                    errors++;
                end else begin
                    want = decoded_words.pop_front();
                    if (i_out_bytes !== want.bytes) begin
                        $error("out_bytes mismatch: expected %h, actual %h",
                               want.bytes, i_out_bytes);
                        errors++;
                    end
                    if (i_out_count !== want.count) begin
                        $error("out_count mismatch: expected %0d, actual %0d",
                               want.count, i_out_count);
                        errors++;
                    end
                    if (i_out_last !== want.last) begin
                        $error("out_last mismatch: expected %0b, actual %0b",
                               want.last, i_out_last);
                        errors++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                decode_word(i_in_byte, i_block_start);
            end
        end
        o_error_count <= errors;
        o_results_owed <= decoded_words.size();
    end

endmodule

@@ tb/lzss_window_decompressor_core_test.sv @@
`timescale 1ns / 1ps
// Top of the LZSS window decompressor test: clock, reset, input words and
// output stalls, and the verdict. Depends on lzwd_pkg, the block and its checker.
module lzss_window_decompressor_core_test;
    import lzwd_pkg::*;

    // Total input words, directed part included.
    localparam int ITEMS = 360;
    // The limit stays well above the slowest correct run (every word a 273-byte
    // match, every output word stalled for the longest pattern, every input word
    // after a full gap), the clearing pass included.
    localparam int CYCLE_LIMIT = 1_200_000;
    // Settling time after the last expected word; it covers any word still
    // being decoded that makes no output.
    localparam int DRAIN_CYCLES = 40;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  in_byte = 8'h00;
    logic        block_start = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [63:0] out_bytes;
    logic [3:0]  out_count;
    logic        out_last;
    int          error_count;
    int          results_owed;

    int          cycle_count = 0;
    int          burst_left = 0;
    int          words_sent = 0;
    logic [11:0] wr_guess = '0;
    logic        draining = 1'b0;

    int          stall_mode = 0;
    int          stall_mode_left = 0;
    logic [7:0]  stall_mask = 8'h00;
    logic [2:0]  stall_phase = '0;
    logic        stall_next;

    lzss_window_decompressor_core DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_in_byte     (in_byte),
        .i_block_start (block_start),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_out_bytes   (out_bytes),
        .o_out_count   (out_count),
        .o_out_last    (out_last)
    );

    lzss_window_decompressor_core_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_in_byte      (in_byte),
        .i_block_start  (block_start),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_out_bytes    (out_bytes),
        .i_out_count    (out_count),
        .i_out_last     (out_last),
        .o_error_count  (error_count),
        .o_results_owed (results_owed)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Guards against a hung handshake or a lost output word.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("lzss_window_decompressor_core test failed");
            $finish;
        end
    end

    // Receiver stalls. The pattern is redrawn at random between
    // no stalls at all, light and heavy random stalls, and a rotating bit mask
    // that gives a fixed period. Stalls stop once all input has been sent so
    // that a stray extra word would show up at once.
    always @(negedge clk) begin
        if (stall_mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_mode_left = $urandom_range(32, 256);
            stall_mask = 8'($urandom_range(1, 255));
        end else begin
            stall_mode_left--;
        end
        case (stall_mode)
            0: stall_next = 1'b0;
            1: stall_next = ($urandom_range(0, 3) == 0);
            2: stall_next = 1'($urandom_range(0, 1));
            default: begin
                stall_next = stall_mask[stall_phase];
                stall_phase = stall_phase + 1'b1;
            end
        endcase
        out_stall <= draining ? 1'b0 : stall_next;
    end

    // Sends one word, called and returning at a falling edge. Words go out in
    // bursts of random length; between bursts valid drops for a random gap,
    // and a gap of zero lets two bursts run together. Valid stays high from
    // one word to the next inside a burst and is only assigned once per step.
    task automatic send_word(input logic [7:0] value, input logic start);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 32);
        end
        in_valid <= 1'b1;
        in_byte <= value;
        block_start <= start;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        @(negedge clk);
        burst_left--;
        words_sent++;
    endtask

    // The write position is followed roughly here only so that match
    // positions can be aimed just behind it, where the data is recent and
    // source and destination overlap.
    task automatic send_literal(input logic [7:0] value);
        send_word(value, 1'b0);
        wr_guess = wr_guess + 1'b1;
    endtask

    task automatic send_match(input logic [11:0] pos, input logic [3:0] code,
                              input logic [7:0] ext);
        send_word(pos[7:0], 1'b0);
        send_word({code, pos[11:8]}, 1'b0);
        if (code == LEN_EXT_CODE) begin
            send_word(ext, 1'b0);
            wr_guess = wr_guess + 12'(LEN_EXT_BASE) + 12'(ext);
        end else begin
            wr_guess = wr_guess + 12'(LEN_BASE) + 12'(code);
        end
    endtask

    initial begin : stimulus
        logic [7:0]  flags;
        logic [11:0] pos;
        logic [3:0]  code;
        logic        restart;
        int          cut;

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // A flag byte of all zeros, then eight literals at the byte extremes
        // and alternating bit patterns.
        send_word(8'h00, 1'b1);
        send_literal(8'h00);
        send_literal(8'hff);
        send_literal(8'h01);
        send_literal(8'h80);
        send_literal(8'h55);
        send_literal(8'haa);
        send_literal(8'h7f);
        send_literal(8'hfe);

        // A flag byte of all ones. The shortest match; a match whose source
        // wraps past the top of the window; the longest match, reading from
        // one byte behind the write position so that it repeats that byte.
        send_word(8'hff, 1'b0);
        send_match(12'h000, 4'd0, 8'h00);
        send_match(12'hfff, LEN_EXT_CODE, 8'h00);
        send_match(wr_guess - 12'd1, LEN_EXT_CODE, 8'hff);

        // Block start after the first byte of a match: the match is dropped,
        // along with the rest of the flag bits, and the word is a flag byte.
        send_word(8'h12, 1'b0);
        send_word(8'h55, 1'b1);
        send_match(12'h034, 4'd14, 8'h00);
        send_literal(8'h5a);

        // Block start while the length extension of a match is awaited.
        send_word(8'h10, 1'b0);
        send_word(8'hf3, 1'b0);

        // Random part: mostly complete blocks of a flag byte and its eight
        // tokens with random content, some blocks cut off at a random token,
        // possibly inside a match, and some bursts of random noise words.
        // After a cut or noise the next flag byte carries block start.
        restart = 1'b1;
        while (words_sent < ITEMS) begin
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 6)) begin
                    send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                end
                restart = 1'b1;
            end else begin
                flags = 8'($urandom_range(0, 255));
                send_word(flags, restart ? 1'b1 : ($urandom_range(0, 3) == 0));
                restart = 1'b0;
                cut = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : 8;
                for (int k = 0; k < 8; k++) begin
                    if ($urandom_range(0, 1) == 0) begin
                        pos = wr_guess - 12'($urandom_range(1, 40));
                    end else begin
                        pos = 12'($urandom_range(0, 4095));
                    end
                    code = ($urandom_range(0, 3) == 0) ? LEN_EXT_CODE
                                                       : 4'($urandom_range(0, 14));
                    if (k == cut) begin
                        if (flags[k]) begin
                            send_word(pos[7:0], 1'b0);
                            if ($urandom_range(0, 1) == 0) begin
                                send_word({LEN_EXT_CODE, pos[11:8]}, 1'b0);
                            end
                        end
                        restart = 1'b1;
                        break;
                    end
                    if (flags[k]) begin
                        send_match(pos, code, 8'($urandom_range(0, 255)));
                    end else begin
                        send_literal(8'($urandom_range(0, 255)));
                    end
                end
            end
        end

        in_valid <= 1'b0;
        draining = 1'b1;
        while (results_owed != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0) begin
            $display("lzss_window_decompressor_core test passed");
        end else begin
            $display("lzss_window_decompressor_core test failed");
        end
        $finish;
    end

endmodule
